/* rtl/lwfg_pkg.sv */
`default_nettype none
package lwfg_pkg;

    localparam int PIXEL_COUNT = 60;

    // field widths
    localparam int PIX_W   = 6;
    localparam int LEVEL_W = 8;
    localparam int PCT_W   = 7;

    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

    // distance table, one entry per ring distance 0 .. PIXEL_COUNT/2
    localparam int DIST_DEPTH = PIXEL_COUNT / 2 + 1;
    localparam int DIST_W     = (DIST_DEPTH > 1) ? $clog2(DIST_DEPTH) : 1;
    localparam logic [DIST_W-1:0] DIST_LAST = DIST_W'(PIXEL_COUNT / 2);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ramp-step divider, one quotient bit per cycle
    localparam int DIV_CNT_W = (PCT_W > 1) ? $clog2(PCT_W) : 1;

    // floor(x / 100) == (x * 5243) >> 19 for x below 2^15
    localparam int PROD_W      = LEVEL_W + PCT_W;
    localparam int RECIP_W     = 13;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED   = 3'd0,
        REG_GREEN = 3'd1,
        REG_BLUE  = 3'd2,
        REG_BASE  = 3'd3,
        REG_PEAK  = 3'd4,
        REG_WIDTH = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [PCT_W-1:0]   base_percent;
        logic [PCT_W-1:0]   peak_percent;
        logic [PCT_W-1:0]   ramp_span;
    } cfg_t;

    typedef struct packed {
        logic             push;
        logic [PIX_W-1:0] center;
    } q_wr_t;

    typedef struct packed {
        logic             avail;
        logic [PIX_W-1:0] center;
    } q_rd_t;

    typedef struct packed {
        logic             start;
        logic [PCT_W-1:0] num;
        logic [PCT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quo;
        logic [PCT_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FILL,
        BK_EMIT
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/lwfg_ram.sv */
`default_nettype none
module lwfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/lwfg_queue.sv */
`default_nettype none
module lwfg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lwfg_pkg::q_wr_t wr,
    output logic                full,
    input  wire logic           pop,
    output lwfg_pkg::q_rd_t     rd
);
    import lwfg_pkg::*;

    logic [PIX_W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd.avail  = (count_reg != '0);
    assign rd.center = entry_reg[rd_ptr_reg];

    assign do_push = wr.push && !full;
    assign do_pop  = pop && rd.avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr.center;
        end
    end

endmodule
`default_nettype wire

/* rtl/lwfg_front.sv */
`default_nettype none
module lwfg_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            frame_request,
    input  wire logic            q_full,
    output lwfg_pkg::q_wr_t      q_wr
);
    import lwfg_pkg::*;

    logic [PIX_W-1:0] center_reg;
    logic [PIX_W-1:0] center_next;
    logic             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // a request of 0 is taken and dropped here
    assign q_wr.push   = accept && frame_request;
    assign q_wr.center = center_reg;

    always_comb
    begin
        center_next = center_reg;
        if (q_wr.push)
        begin
            center_next = (center_reg == PIX_LAST) ? '0 : center_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
        end
        else
        begin
            center_reg <= center_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lwfg_div.sv */
`default_nettype none
module lwfg_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lwfg_pkg::div_req_t req,
    output lwfg_pkg::div_rsp_t  rsp
);
    import lwfg_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PCT_W-1:0]     num_reg;
    logic [PCT_W-1:0]     den_reg;
    logic [PCT_W-1:0]     quo_reg;
    logic [PCT_W-1:0]     rem_reg;
    logic [PCT_W:0]       shifted;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, num_reg[PCT_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PCT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[PCT_W-2:0], 1'b0};
            rem_reg <= ge ? PCT_W'(shifted - {1'b0, den_reg}) : PCT_W'(shifted);
            quo_reg <= {quo_reg[PCT_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

/* rtl/lwfg_back.sv */
`default_nettype none
module lwfg_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lwfg_pkg::cfg_t     cfg,
    input  wire lwfg_pkg::q_rd_t    q_rd,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [lwfg_pkg::PIX_W-1:0]   pixel_index,
    output logic [lwfg_pkg::LEVEL_W-1:0] pixel_red,
    output logic [lwfg_pkg::LEVEL_W-1:0] pixel_green,
    output logic [lwfg_pkg::LEVEL_W-1:0] pixel_blue,
    output logic                    last_pixel
);
    import lwfg_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic [PIX_W-1:0]  center_reg;
    logic [PIX_W-1:0]  center_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  pix_next;
    logic [DIST_W-1:0] d_reg;
    logic [DIST_W-1:0] d_next;
    logic [PCT_W-1:0]  q_reg;
    logic [PCT_W-1:0]  q_next;
    logic [PCT_W-1:0]  r_reg;
    logic [PCT_W-1:0]  r_next;
    logic [PCT_W-1:0]  qa_reg;
    logic [PCT_W-1:0]  qa_next;
    logic [PCT_W-1:0]  ra_reg;
    logic [PCT_W-1:0]  ra_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              ram_we;
    logic [PCT_W-1:0]  fill_pct;
    logic [PCT_W-1:0]  ram_rd_data;
    logic [DIST_W-1:0] rd_dist;
    logic              issue;
    logic              adv;

    logic [PCT_W:0]    r_sum;
    logic              r_wrap;
    logic              falling;
    logic [PCT_W-1:0]  delta;

    logic [PIX_W-1:0]  diff;
    logic [PIX_W:0]    ring_d;

    // pipeline
    logic                s1_valid_reg;
    logic [PIX_W-1:0]    s1_idx_reg;
    logic                s1_last_reg;
    logic                s2_valid_reg;
    logic [PIX_W-1:0]    s2_idx_reg;
    logic                s2_last_reg;
    logic [PROD_W-1:0]   s2_red_reg;
    logic [PROD_W-1:0]   s2_green_reg;
    logic [PROD_W-1:0]   s2_blue_reg;
    logic                s3_valid_reg;
    logic [PIX_W-1:0]    s3_idx_reg;
    logic                s3_last_reg;
    logic [SCALED_W-1:0] s3_red_reg;
    logic [SCALED_W-1:0] s3_green_reg;
    logic [SCALED_W-1:0] s3_blue_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_idx_reg;
    logic                out_last_reg;
    logic [LEVEL_W-1:0]  out_red_reg;
    logic [LEVEL_W-1:0]  out_green_reg;
    logic [LEVEL_W-1:0]  out_blue_reg;

    function automatic logic [LEVEL_W-1:0] sat_channel(input logic [SCALED_W-1:0] scaled);
        logic [SCALED_W-RECIP_SHIFT-1:0] v;
        v = scaled[SCALED_W-1:RECIP_SHIFT];
        return (v > (SCALED_W-RECIP_SHIFT)'(255)) ? LEVEL_W'(255) : LEVEL_W'(v);
    endfunction

    // ramp step per distance: |peak - base| / width as quotient and remainder
    assign falling = (cfg.peak_percent >= cfg.base_percent);
    assign delta   = falling ? (cfg.peak_percent - cfg.base_percent)
                             : (cfg.base_percent - cfg.peak_percent);

    lwfg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // q_reg tracks floor(d * |peak - base| / width) while d stays inside the wave
    assign r_sum  = {1'b0, r_reg} + {1'b0, ra_reg};
    assign r_wrap = (r_sum >= {1'b0, cfg.ramp_span});

    always_comb
    begin
        if ({{(PCT_W-DIST_W){1'b0}}, d_reg} > cfg.ramp_span)
        begin
            fill_pct = cfg.base_percent;
        end
        else if (falling)
        begin
            fill_pct = cfg.peak_percent - q_reg;
        end
        else
        begin
            fill_pct = cfg.peak_percent + q_reg;
        end
    end

    // ring distance of the pixel being issued
    assign diff   = (pix_reg >= center_reg) ? (pix_reg - center_reg) : (center_reg - pix_reg);
    assign ring_d = ({1'b0, diff} > (PIX_W+1)'(PIXEL_COUNT / 2))
                    ? ((PIX_W+1)'(PIXEL_COUNT) - {1'b0, diff}) : {1'b0, diff};
    assign rd_dist = DIST_W'(ring_d);

    lwfg_ram #(
        .WIDTH (PCT_W),
        .DEPTH (DIST_DEPTH)
    ) u_pct_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (d_reg),
        .wr_data (fill_pct),
        .rd_en   (issue),
        .rd_addr (rd_dist),
        .rd_data (ram_rd_data)
    );

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        center_next   = center_reg;
        pix_next      = pix_reg;
        d_next        = d_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        qa_next       = qa_reg;
        ra_next       = ra_reg;
        q_pop         = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = delta;
        div_req.den   = cfg.ramp_span;
        ram_we        = 1'b0;
        issue         = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_rd.avail)
                begin
                    q_pop         = 1'b1;
                    center_next   = q_rd.center;
                    div_req.start = 1'b1;
                    state_next    = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    qa_next    = div_rsp.quo;
                    ra_next    = div_rsp.rem;
                    d_next     = '0;
                    q_next     = '0;
                    r_next     = '0;
                    state_next = BK_FILL;
                end
            end
            BK_FILL:
            begin
                ram_we = 1'b1;
                d_next = d_reg + 1'b1;
                q_next = q_reg + qa_reg + PCT_W'(r_wrap);
                r_next = r_wrap ? PCT_W'(r_sum - {1'b0, cfg.ramp_span}) : PCT_W'(r_sum);
                if (d_reg == DIST_LAST)
                begin
                    pix_next   = '0;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (adv)
                begin
                    issue    = 1'b1;
                    pix_next = pix_reg + 1'b1;
                    if (pix_reg == PIX_LAST)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg <= center_next;
        pix_reg    <= pix_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        qa_reg     <= qa_next;
        ra_reg     <= ra_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg  <= pix_reg;
            s1_last_reg <= (pix_reg == PIX_LAST);

            s2_idx_reg   <= s1_idx_reg;
            s2_last_reg  <= s1_last_reg;
            s2_red_reg   <= PROD_W'(cfg.red_level) * PROD_W'(ram_rd_data);
            s2_green_reg <= PROD_W'(cfg.green_level) * PROD_W'(ram_rd_data);
            s2_blue_reg  <= PROD_W'(cfg.blue_level) * PROD_W'(ram_rd_data);

            s3_idx_reg   <= s2_idx_reg;
            s3_last_reg  <= s2_last_reg;
            s3_red_reg   <= SCALED_W'(s2_red_reg) * SCALED_W'(RECIP_100);
            s3_green_reg <= SCALED_W'(s2_green_reg) * SCALED_W'(RECIP_100);
            s3_blue_reg  <= SCALED_W'(s2_blue_reg) * SCALED_W'(RECIP_100);

            out_idx_reg   <= s3_idx_reg;
            out_last_reg  <= s3_last_reg;
            out_red_reg   <= sat_channel(s3_red_reg);
            out_green_reg <= sat_channel(s3_green_reg);
            out_blue_reg  <= sat_channel(s3_blue_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = out_idx_reg;
    assign pixel_red   = out_red_reg;
    assign pixel_green = out_green_reg;
    assign pixel_blue  = out_blue_reg;
    assign last_pixel  = out_last_reg;

endmodule
`default_nettype wire

/* rtl/led_wave_frame_generator_core.sv */
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  frame_request
// out       result     out_valid/out_stall  pixel_index, pixel_red/green/blue, last_pixel
// cfg       write      cfg_write            cfg_index, cfg_data
//
// A frame request runs the ramp-step divider, fills the percent table with one entry
// per ring distance, then issues the PIXEL_COUNT pixels in turn through the single
// read port of that table.
// A request of 0 is taken and yields nothing; the front keeps taking
// requests until the two-entry queue is full, then raises in_stall.
// out_stall holds the four-stage pixel pipeline in place. Reset is asynchronous.
module led_wave_frame_generator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          frame_request,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lwfg_pkg::PIX_W-1:0]         pixel_index,
    output logic [lwfg_pkg::LEVEL_W-1:0]       pixel_red,
    output logic [lwfg_pkg::LEVEL_W-1:0]       pixel_green,
    output logic [lwfg_pkg::LEVEL_W-1:0]       pixel_blue,
    output logic                               last_pixel,
    input  wire logic                          cfg_write,
    input  wire logic [lwfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lwfg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lwfg_pkg::*;

    cfg_t  cfg_reg;
    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_level    <= '0;
            cfg_reg.green_level  <= '0;
            cfg_reg.blue_level   <= '0;
            cfg_reg.base_percent <= PCT_W'(20);
            cfg_reg.peak_percent <= PCT_W'(100);
            cfg_reg.ramp_span    <= PCT_W'(5);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RED:   cfg_reg.red_level    <= cfg_data;
                REG_GREEN: cfg_reg.green_level  <= cfg_data;
                REG_BLUE:  cfg_reg.blue_level   <= cfg_data;
                REG_BASE:  cfg_reg.base_percent <= cfg_data[PCT_W-1:0];
                REG_PEAK:  cfg_reg.peak_percent <= cfg_data[PCT_W-1:0];
                REG_WIDTH: cfg_reg.ramp_span    <= cfg_data[PCT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lwfg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame_request (frame_request),
        .q_full        (q_full),
        .q_wr          (q_wr)
    );

    lwfg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rd    (q_rd)
    );

    lwfg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_rd        (q_rd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .last_pixel  (last_pixel)
    );

endmodule
`default_nettype wire
